// ===== rtl/hdlc_frame_receiver_crc_check_top_defines.svh =====
// assertion macros for the hdlc frame receiver
`ifndef HDLC_FRAME_RECEIVER_CRC_CHECK_TOP_DEFINES_SVH
`define HDLC_FRAME_RECEIVER_CRC_CHECK_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clock, off during reset
`define HRX_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define HRX_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define HRX_ASSERT_IMP(name, ante, cons)
`define HRX_ASSERT_NXT(name, ante, cons)

`endif

`endif

// ===== rtl/hdlc_rx_pkg.sv =====
// shared types and constants for the hdlc frame receiver
`timescale 1ns / 1ps

package hdlc_rx_pkg;

   localparam int FRAME_BYTES = 256;
   localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);

   localparam logic [7:0]  FLAG_BYTE     = 8'h7E;
   localparam logic [7:0]  ESC_BYTE      = 8'h7D;
   localparam logic [7:0]  ESC_XOR       = 8'h20;
   localparam logic [15:0] CRC_POLY_INIT = 16'h8408;
   localparam logic [15:0] CRC_SEED_INIT = 16'hFFFF;

   typedef enum logic [0:0] {
      CSR_CRC_POLY = 1'b0,
      CSR_CRC_SEED = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2,
      KIND_ABORT   = 2'd3
   } kind_type;

   typedef struct packed {
      logic               valid;
      kind_type           kind;
      logic [7:0]         payload;
      logic [COUNT_W-1:0] frame_bytes;
   } result_type;

endpackage

// ===== rtl/hdlc_rx_crc_unit.sv =====
// byte-wide reflected crc-16 update
`timescale 1ns / 1ps

module hdlc_rx_crc_unit
   import hdlc_rx_pkg::*;
(
   input  logic [15:0] crc_acc,
   input  logic [7:0]  data_byte,
   input  logic [15:0] crc_poly,
   output logic [15:0] crc_next
);

   always_comb begin
      logic [15:0] acc;
      acc = crc_acc ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ crc_poly;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

// ===== rtl/hdlc_rx_deframer.sv =====
// frame state, unescaping, crc hold-back and end-of-frame check
`timescale 1ns / 1ps
`include "hdlc_frame_receiver_crc_check_top_defines.svh"

module hdlc_rx_deframer
   import hdlc_rx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] crc_poly,
   input  logic [15:0] crc_seed,
   output result_type  result
);

   logic               in_frame_ff, in_frame_in;
   logic               escape_ff, escape_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         held_ff [2];
   logic [7:0]         held_in [2];
   logic [15:0]        crc_fed;
   logic [7:0]         data_byte;
   logic [COUNT_W-1:0] count_inc;

   hdlc_rx_crc_unit u_crc (
      .crc_acc   (crc_ff),
      .data_byte (held_ff[0]),
      .crc_poly  (crc_poly),
      .crc_next  (crc_fed)
   );

   assign data_byte = escape_ff ? (rx_byte ^ ESC_XOR) : rx_byte;
   assign count_inc = count_ff + COUNT_W'(1);

   always_comb begin
      in_frame_in = in_frame_ff;
      escape_in   = escape_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      held_in     = held_ff;
      result      = '0;
      if (!in_frame_ff) begin
         if (rx_byte == FLAG_BYTE) begin
            in_frame_in = 1'b1;
            escape_in   = 1'b0;
            count_in    = '0;
            crc_in      = crc_seed;
         end
      end else if (rx_byte == FLAG_BYTE) begin
         in_frame_in = 1'b0;
         if (count_ff >= COUNT_W'(3)) begin
            result.valid       = 1'b1;
            result.kind        = ({held_ff[0], held_ff[1]} == crc_ff) ? KIND_GOOD : KIND_BAD;
            result.frame_bytes = count_ff;
         end
      end else if (rx_byte == ESC_BYTE) begin
         escape_in = 1'b1;
      end else if (count_ff >= COUNT_W'(FRAME_BYTES)) begin
         // buffer full: drop the frame
         in_frame_in        = 1'b0;
         result.valid       = 1'b1;
         result.kind        = KIND_ABORT;
         result.frame_bytes = count_ff;
      end else begin
         escape_in = 1'b0;
         count_in  = count_inc;
         if (count_ff < COUNT_W'(2)) begin
            held_in[count_ff[0]] = data_byte;
         end else begin
            // oldest held byte leaves as payload and enters the crc
            crc_in             = crc_fed;
            held_in[0]         = held_ff[1];
            held_in[1]         = data_byte;
            result.valid       = 1'b1;
            result.kind        = KIND_PAYLOAD;
            result.payload     = held_ff[0];
            result.frame_bytes = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         escape_ff   <= 1'b0;
         count_ff    <= '0;
         crc_ff      <= CRC_SEED_INIT;
      end else if (step) begin
         in_frame_ff <= in_frame_in;
         escape_ff   <= escape_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         held_ff <= held_in;
      end
   end

   `HRX_ASSERT_IMP(a_count_bounded, 1'b1, count_ff <= COUNT_W'(FRAME_BYTES))
   `HRX_ASSERT_NXT(a_end_leaves_frame, step && result.valid && result.kind != KIND_PAYLOAD,
                   !in_frame_ff)
   `HRX_ASSERT_NXT(a_payload_after_hold, step && result.valid && result.kind == KIND_PAYLOAD,
                   in_frame_ff && count_ff >= COUNT_W'(3))

endmodule

// ===== rtl/hdlc_rx_out_reg.sv =====
// result register on the response stream
`timescale 1ns / 1ps

module hdlc_rx_out_reg
   import hdlc_rx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  result_type  result,
   output logic        room,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic [1:0]  rsp_tuser
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign room = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      if (step) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'b0, res_ff.frame_bytes, res_ff.payload};
   assign rsp_tuser  = res_ff.kind;

endmodule

// ===== rtl/hdlc_frame_receiver_crc_check_top.sv =====
// hdlc frame receiver: unescaping, hold-back of the crc pair, crc-16 check
// a req transfer reaches rsp_tvalid through the input register and then the result register
// throughput: one byte per cycle, no bubbles while rsp_tready stays high
// bytes that give no result leave nothing on the response side
// synchronous active-high reset: outside a frame, control and csr registers at power-up values
`timescale 1ns / 1ps

module hdlc_frame_receiver_crc_check_top
   import hdlc_rx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] payload, [16:8] frame_bytes, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic [15:0] poly_ff, seed_ff;
   logic        room;
   logic        step;
   result_type  result;

   assign step       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;
   assign in_valid_in = req_tvalid || (in_valid_ff && !room);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= CRC_POLY_INIT;
         seed_ff <= CRC_SEED_INIT;
      end else if (csr_we && !csr_index[1]) begin
         case (csr_index_type'(csr_index[0]))
            CSR_CRC_POLY: poly_ff <= csr_wdata;
            CSR_CRC_SEED: seed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   hdlc_rx_deframer u_deframer (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rx_byte  (in_byte_ff),
      .crc_poly (poly_ff),
      .crc_seed (seed_ff),
      .result   (result)
   );

   hdlc_rx_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .result     (result),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
